@@ rtl/hbss_pkg.sv @@
// ----------------------------------------------------------------------------
// hbss_pkg
// Shared types and constants of the hash based server selector.
// ----------------------------------------------------------------------------
`default_nettype none

package hbss_pkg;

	// Message hash: hash = (hash * HASH_MULT + byte) mod HASH_MOD.
	localparam int unsigned HASH_W      = 13;
	localparam int unsigned HASH_MULT   = 113;
	localparam int unsigned HASH_MOD    = 6271;
	localparam int unsigned BYTE_W      = 8;
	localparam int unsigned SID_W       = 16;

	// hash * 113 + byte stays below 2^20.
	localparam int unsigned X_W         = 20;
	// floor(2^24 / 6271); the quotient estimate is low by at most one.
	localparam int unsigned RECIP       = 2675;
	localparam int unsigned RECIP_W     = 12;
	localparam int unsigned RECIP_SHIFT = 24;
	localparam int unsigned Q_W         = 8;
	localparam int unsigned STEP_W      = $clog2(HASH_W);

	typedef enum logic [1:0] {
		OP_ADD  = 2'd0,
		OP_DEL  = 2'd1,
		OP_HASH = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_FULL      = 2'd1,
		STAT_NOT_FOUND = 2'd2,
		STAT_EMPTY     = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_HASH,
		S_MOD,
		S_SEL,
		S_SEL_OUT,
		S_DEL_LAST,
		S_DEL_SCAN
	} state_t;

endpackage

`default_nettype wire

@@ rtl/hash_based_server_selector_top.sv @@
// ----------------------------------------------------------------------------
// hash_based_server_selector_top
// Server table with add, delete and hash-based selection of a server.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; every add, delete
// and final hash byte gives one result, shown for exactly one cycle with done
// high, and the receiver cannot stall it. A hash byte passes through the
// two-stage hash pipeline; a final byte then goes through the bit-serial
// remainder unit and a table read. A delete scans the table through its
// single read port, one entry a cycle, and stops at a match or at the last
// entry. A delete on an empty table reports not found without a scan, and an
// unused op code gives no result.
`default_nettype none

module hash_based_server_selector_top #(
	parameter int unsigned MAX_SERVERS = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic [1:0]                    op,
	input  wire logic [hbss_pkg::SID_W-1:0]    server_id,
	input  wire logic [hbss_pkg::BYTE_W-1:0]   id_byte,
	input  wire logic                          last_byte,
	output logic                               done,
	output logic      [1:0]                    status,
	output logic      [hbss_pkg::SID_W-1:0]    chosen_server
);

	localparam int unsigned CNT_W = $clog2(MAX_SERVERS + 1);
	localparam int unsigned IDX_W = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
	localparam int unsigned HW    = hbss_pkg::HASH_W;
	localparam int unsigned SIDW  = hbss_pkg::SID_W;

	hbss_pkg::state_t state_q, state_next;

	logic [CNT_W-1:0] count_q;
	logic [HW-1:0]    hash_q;
	logic [SIDW-1:0]  sid_q, last_sid_q;
	logic             last_q;
	logic [IDX_W-1:0] scan_idx_q;

	logic                     done_q;
	hbss_pkg::status_t        status_q;
	logic [SIDW-1:0]          chosen_q;

	logic             accept;
	logic             full, empty;
	logic [CNT_W-1:0] count_m1;
	logic [IDX_W-1:0] last_idx;
	logic             match, scan_end;

	logic [IDX_W-1:0] rd_addr, wr_addr;
	logic [SIDW-1:0]  rd_data, wr_data;
	logic             wr_en;

	logic             hash_go, hash_done;
	logic [HW-1:0]    hash_new;
	logic             mod_start, mod_done;
	logic [CNT_W-1:0] mod_rem;

	// Actions decoded from the state.
	logic              cnt_inc, cnt_dec, hash_load, hash_clear;
	logic              scan_first, scan_step, last_load;
	logic              res_set;
	hbss_pkg::status_t res_status;
	logic [SIDW-1:0]   res_chosen;

	assign accept   = start && !busy;
	assign full     = (count_q == CNT_W'(MAX_SERVERS));
	assign empty    = (count_q == '0);
	assign count_m1 = count_q - CNT_W'(1);
	assign last_idx = count_m1[IDX_W-1:0];
	assign match    = (rd_data == sid_q);
	assign scan_end = (scan_idx_q == last_idx);

	hbss_table_mem #(
		.DEPTH (MAX_SERVERS),
		.AW    (IDX_W)
	) u_mem (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	hbss_hash_unit u_hash (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (hash_go),
		.hash_in  (hash_q),
		.byte_in  (id_byte),
		.done     (hash_done),
		.hash_out (hash_new)
	);

	// The remainder unit latches the freshly updated hash as it starts.
	hbss_mod_unit #(
		.CNT_W (CNT_W)
	) u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (mod_start),
		.dividend  (hash_new),
		.divisor   (count_q),
		.done      (mod_done),
		.remainder (mod_rem)
	);

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			hbss_pkg::S_IDLE: begin
				if (accept) begin
					unique case (op)
						hbss_pkg::OP_HASH: state_next = hbss_pkg::S_HASH;
						hbss_pkg::OP_DEL: begin
							if (!empty) begin
								state_next = hbss_pkg::S_DEL_LAST;
							end
						end
						default: state_next = hbss_pkg::S_IDLE;
					endcase
				end
			end
			hbss_pkg::S_HASH: begin
				if (hash_done) begin
					state_next = (last_q && !empty) ? hbss_pkg::S_MOD : hbss_pkg::S_IDLE;
				end
			end
			hbss_pkg::S_MOD: begin
				if (mod_done) begin
					state_next = hbss_pkg::S_SEL;
				end
			end
			hbss_pkg::S_SEL:      state_next = hbss_pkg::S_SEL_OUT;
			hbss_pkg::S_SEL_OUT:  state_next = hbss_pkg::S_IDLE;
			hbss_pkg::S_DEL_LAST: state_next = hbss_pkg::S_DEL_SCAN;
			hbss_pkg::S_DEL_SCAN: begin
				if (match || scan_end) begin
					state_next = hbss_pkg::S_IDLE;
				end
			end
			default: state_next = hbss_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		rd_addr    = last_idx;
		wr_en      = 1'b0;
		wr_addr    = count_q[IDX_W-1:0];
		wr_data    = server_id;
		hash_go    = 1'b0;
		mod_start  = 1'b0;
		cnt_inc    = 1'b0;
		cnt_dec    = 1'b0;
		hash_load  = 1'b0;
		hash_clear = 1'b0;
		scan_first = 1'b0;
		scan_step  = 1'b0;
		last_load  = 1'b0;
		res_set    = 1'b0;
		res_status = hbss_pkg::STAT_OK;
		res_chosen = '0;
		unique case (state_q)
			hbss_pkg::S_IDLE: begin
				// The read of the last entry is issued here for a delete.
				if (accept) begin
					unique case (op)
						hbss_pkg::OP_ADD: begin
							res_set = 1'b1;
							if (full) begin
								res_status = hbss_pkg::STAT_FULL;
							end else begin
								wr_en   = 1'b1;
								cnt_inc = 1'b1;
							end
						end
						hbss_pkg::OP_DEL: begin
							if (empty) begin
								res_set    = 1'b1;
								res_status = hbss_pkg::STAT_NOT_FOUND;
							end
						end
						hbss_pkg::OP_HASH: hash_go = 1'b1;
						default: ;
					endcase
				end
			end
			hbss_pkg::S_HASH: begin
				if (hash_done) begin
					if (!last_q) begin
						hash_load = 1'b1;
					end else if (empty) begin
						hash_clear = 1'b1;
						res_set    = 1'b1;
						res_status = hbss_pkg::STAT_EMPTY;
					end else begin
						hash_load = 1'b1;
						mod_start = 1'b1;
					end
				end
			end
			hbss_pkg::S_MOD: ;
			hbss_pkg::S_SEL: begin
				rd_addr    = mod_rem[IDX_W-1:0];
				hash_clear = 1'b1;
			end
			hbss_pkg::S_SEL_OUT: begin
				res_set    = 1'b1;
				res_chosen = rd_data;
			end
			hbss_pkg::S_DEL_LAST: begin
				last_load  = 1'b1;
				scan_first = 1'b1;
				rd_addr    = '0;
			end
			hbss_pkg::S_DEL_SCAN: begin
				// rd_data holds the entry at scan_idx_q; the next read is
				// issued speculatively and dropped on a match.
				rd_addr = scan_idx_q + IDX_W'(1);
				if (match) begin
					wr_en   = 1'b1;
					wr_addr = scan_idx_q;
					wr_data = last_sid_q;
					cnt_dec = 1'b1;
					res_set = 1'b1;
				end else if (scan_end) begin
					res_set    = 1'b1;
					res_status = hbss_pkg::STAT_NOT_FOUND;
				end else begin
					scan_step = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= hbss_pkg::S_IDLE;
			count_q  <= '0;
			hash_q   <= '0;
			done_q   <= 1'b0;
			status_q <= hbss_pkg::STAT_OK;
		end else begin
			state_q <= state_next;
			if (cnt_inc) begin
				count_q <= count_q + CNT_W'(1);
			end else if (cnt_dec) begin
				count_q <= count_m1;
			end
			if (hash_clear) begin
				hash_q <= '0;
			end else if (hash_load) begin
				hash_q <= hash_new;
			end
			done_q <= res_set;
			if (res_set) begin
				status_q <= res_status;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sid_q  <= server_id;
			last_q <= last_byte;
		end
		if (last_load) begin
			last_sid_q <= rd_data;
		end
		if (scan_first) begin
			scan_idx_q <= '0;
		end else if (scan_step) begin
			scan_idx_q <= scan_idx_q + IDX_W'(1);
		end
		if (res_set) begin
			chosen_q <= res_chosen;
		end
	end

	assign busy          = (state_q != hbss_pkg::S_IDLE);
	assign done          = done_q;
	assign status        = status_q;
	assign chosen_server = chosen_q;

`ifndef SYNTH
	// The remainder unit must never run against an empty table.
	a_mod_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == hbss_pkg::S_MOD) |-> (count_q != '0))
		else $error("remainder unit running with empty table");

	// An add into a table with room grows the count by one.
	a_add_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (op == hbss_pkg::OP_ADD) && !full) |=>
		(count_q == $past(count_q) + CNT_W'(1)))
		else $error("add did not grow the table");

	// An empty-table report only appears while the table is empty.
	a_empty_report: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && (status_q == hbss_pkg::STAT_EMPTY)) |-> (count_q == '0))
		else $error("empty report with servers present");

	// The count never passes the table capacity; checked as done rises.
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(done_q) |-> (count_q <= CNT_W'(MAX_SERVERS)))
		else $error("server count beyond capacity");
`endif

endmodule

`default_nettype wire

@@ rtl/hbss_table_mem.sv @@
// ----------------------------------------------------------------------------
// hbss_table_mem
// Server table storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module hbss_table_mem #(
	parameter int unsigned DEPTH = 16,
	parameter int unsigned AW    = 4
) (
	input  wire logic                          clk,
	input  wire logic                          we,
	input  wire logic [AW-1:0]                 waddr,
	input  wire logic [hbss_pkg::SID_W-1:0]    wdata,
	input  wire logic [AW-1:0]                 raddr,
	output logic      [hbss_pkg::SID_W-1:0]    rdata
);

	logic [hbss_pkg::SID_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

@@ rtl/hbss_hash_unit.sv @@
// ----------------------------------------------------------------------------
// hbss_hash_unit
// Two-stage hash update: multiply-accumulate, then reduction mod 6271 by a
// reciprocal estimate and one corrective subtract.
// ----------------------------------------------------------------------------
`default_nettype none

module hbss_hash_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          go,
	input  wire logic [hbss_pkg::HASH_W-1:0]   hash_in,
	input  wire logic [hbss_pkg::BYTE_W-1:0]   byte_in,
	output logic                               done,
	output logic      [hbss_pkg::HASH_W-1:0]   hash_out
);

	localparam int unsigned XW = hbss_pkg::X_W;
	localparam int unsigned PW = hbss_pkg::X_W + hbss_pkg::RECIP_W;
	localparam int unsigned QW = hbss_pkg::Q_W;
	localparam int unsigned HW = hbss_pkg::HASH_W;

	logic          v_s1, v_s2;
	logic [XW-1:0] x_s1, x_s2;
	logic [QW-1:0] q_s2;
	logic [XW-1:0] x_next;
	logic [PW-1:0] prod;
	logic [XW-1:0] r_full, r_fix;

	assign x_next = XW'(hash_in) * XW'(hbss_pkg::HASH_MULT) + XW'(byte_in);
	assign prod   = PW'(x_s1) * PW'(hbss_pkg::RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= go;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		x_s1 <= x_next;
		x_s2 <= x_s1;
		q_s2 <= QW'(prod >> hbss_pkg::RECIP_SHIFT);
	end

	// The quotient estimate is exact or one low, so one subtract finishes it.
	assign r_full = x_s2 - XW'(q_s2) * XW'(hbss_pkg::HASH_MOD);
	assign r_fix  = (r_full >= XW'(hbss_pkg::HASH_MOD)) ?
		r_full - XW'(hbss_pkg::HASH_MOD) : r_full;

	assign done     = v_s2;
	assign hash_out = r_fix[HW-1:0];

endmodule

`default_nettype wire

@@ rtl/hbss_mod_unit.sv @@
// ----------------------------------------------------------------------------
// hbss_mod_unit
// Restoring remainder unit: hash mod count, one dividend bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module hbss_mod_unit #(
	parameter int unsigned CNT_W = 5
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [hbss_pkg::HASH_W-1:0]   dividend,
	input  wire logic [CNT_W-1:0]              divisor,
	output logic                               done,
	output logic      [CNT_W-1:0]              remainder
);

	localparam int unsigned HW = hbss_pkg::HASH_W;
	localparam int unsigned SW = hbss_pkg::STEP_W;

	logic             busy_q, done_q;
	logic [SW-1:0]    step_q;
	logic [HW-1:0]    dvd_q;
	logic [CNT_W-1:0] rem_q, rem_next;
	logic [CNT_W:0]   trial, dsr_ext;

	assign trial   = {rem_q, dvd_q[HW-1]};
	assign dsr_ext = {1'b0, divisor};
	// The remainder stays below the divisor, so the trial is below twice it.
	assign rem_next = (trial >= dsr_ext) ? CNT_W'(trial - dsr_ext) : CNT_W'(trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= SW'(HW - 1);
		end else if (busy_q) begin
			if (step_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				step_q <= step_q - SW'(1);
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
		end else if (busy_q) begin
			rem_q <= rem_next;
			dvd_q <= {dvd_q[HW-2:0], 1'b0};
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

`default_nettype wire
